// ===== hdl/polygon_fan_triangulator_defines.svh =====
// ---------------------------------------------------------------------------
// Polygon fan triangulator assertion macros
// Shared concurrent assertion shorthands for the triangulator RTL.
// ---------------------------------------------------------------------------
`ifndef POLYGON_FAN_TRIANGULATOR_DEFINES_SVH
`define POLYGON_FAN_TRIANGULATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PFT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pft assertion failed");

// next-cycle implication, disabled during reset
`define PFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pft assertion failed");

`endif

// ===== hdl/pft_pkg.sv =====
// ---------------------------------------------------------------------------
// Polygon fan triangulator package
// Result word layout, primitive kind codes and internal handoff types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pft_pkg;

   localparam int unsigned RAW_W  = 32;
   localparam int unsigned VTX_W  = 31;
   localparam int unsigned KIND_W = 2;

   // primitive kind codes
   localparam logic [KIND_W-1:0] KIND_TRI  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUAD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BAD  = 2'd2;

   // per-polygon vertex count, saturating at four
   localparam int unsigned CNT_W = 3;
   localparam logic [CNT_W-1:0] CNT_QUAD = 3'd4;

   // one result word
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [VTX_W-1:0]  corner_a;
      logic [VTX_W-1:0]  corner_b;
      logic [VTX_W-1:0]  corner_c;
      logic [VTX_W-1:0]  corner_d;
      logic              last;
   } prim_type;

   // up to two results produced by one accepted index
   typedef struct packed {
      logic     push_first;
      logic     push_second;
      prim_type first;
      prim_type second;
   } emit_type;

endpackage

// ===== hdl/pft_fan.sv =====
// ---------------------------------------------------------------------------
// Polygon fan builder
// Tracks the current polygon and forms the triangle, quad or malformed
// result words caused by each accepted vertex index.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pft_fan (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [pft_pkg::RAW_W-1:0]  raw_index,
   output pft_pkg::emit_type          emit
);

   logic [pft_pkg::VTX_W-1:0] apex_ff,   apex_in;
   logic [pft_pkg::VTX_W-1:0] second_ff, second_in;
   logic [pft_pkg::VTX_W-1:0] prev_ff,   prev_in;
   logic [pft_pkg::CNT_W-1:0] count_ff,  count_in;

   logic                      is_last;
   logic [pft_pkg::VTX_W-1:0] vtx;

   // sign bit marks the closing vertex; its index is the complement
   assign is_last = raw_index[pft_pkg::RAW_W-1];
   assign vtx     = is_last ? ~raw_index[pft_pkg::VTX_W-1:0] : raw_index[pft_pkg::VTX_W-1:0];

   // result formation and next polygon state
   always_comb begin
      apex_in   = apex_ff;
      second_in = second_ff;
      prev_in   = prev_ff;
      count_in  = count_ff;
      emit      = '0;

      if (accept && is_last) begin
         emit.push_first    = 1'b1;
         emit.first.last    = 1'b1;
         emit.first.kind    = pft_pkg::KIND_TRI;
         emit.first.corner_a = apex_ff;
         count_in           = '0;
         unique case (count_ff)
            3'd0: begin
               emit.first.kind     = pft_pkg::KIND_BAD;
               emit.first.corner_a = vtx;
            end
            3'd1: begin
               emit.first.kind     = pft_pkg::KIND_BAD;
               emit.first.corner_b = vtx;
            end
            3'd2: begin
               emit.first.corner_b = second_ff;
               emit.first.corner_c = vtx;
            end
            3'd3: begin
               emit.first.kind     = pft_pkg::KIND_QUAD;
               emit.first.corner_b = second_ff;
               emit.first.corner_c = prev_ff;
               emit.first.corner_d = vtx;
            end
            default: begin
               emit.first.corner_b = prev_ff;
               emit.first.corner_c = vtx;
            end
         endcase
      end else if (accept) begin
         unique case (count_ff)
            3'd0: begin
               apex_in  = vtx;
               count_in = 3'd1;
            end
            3'd1: begin
               second_in = vtx;
               prev_in   = vtx;
               count_in  = 3'd2;
            end
            3'd2: begin
               prev_in  = vtx;
               count_in = 3'd3;
            end
            3'd3: begin
               // fourth vertex: polygon is no quad, release the first two fan triangles
               emit.push_first      = 1'b1;
               emit.first.kind      = pft_pkg::KIND_TRI;
               emit.first.corner_a  = apex_ff;
               emit.first.corner_b  = second_ff;
               emit.first.corner_c  = prev_ff;
               emit.push_second     = 1'b1;
               emit.second.kind     = pft_pkg::KIND_TRI;
               emit.second.corner_a = apex_ff;
               emit.second.corner_b = prev_ff;
               emit.second.corner_c = vtx;
               emit.second.last     = 1'b1;
               prev_in              = vtx;
               count_in             = pft_pkg::CNT_QUAD;
            end
            default: begin
               emit.push_first     = 1'b1;
               emit.first.kind     = pft_pkg::KIND_TRI;
               emit.first.corner_a = apex_ff;
               emit.first.corner_b = prev_ff;
               emit.first.corner_c = vtx;
               emit.first.last     = 1'b1;
               prev_in             = vtx;
               count_in            = pft_pkg::CNT_QUAD;
            end
         endcase
      end
   end

   // polygon state
   always_ff @(posedge clock) begin
      if (reset) begin
         apex_ff   <= '0;
         second_ff <= '0;
         prev_ff   <= '0;
         count_ff  <= '0;
      end else begin
         apex_ff   <= apex_in;
         second_ff <= second_in;
         prev_ff   <= prev_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/pft_queue.sv =====
// ---------------------------------------------------------------------------
// Polygon fan result queue
// Small register queue taking up to two result words per cycle and
// presenting one word per cycle to the result channel while it takes them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polygon_fan_triangulator_defines.svh"

module pft_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  pft_pkg::emit_type  emit,
   output logic               room_two,
   output pft_pkg::prim_type  head,
   output logic               head_valid,
   input  logic               head_taken
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   pft_pkg::prim_type  slot_ff [DEPTH];

   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_plus1, wr_plus2, rd_plus1;
   logic [1:0]       push_n;
   logic             pop;

   // pointer wrap
   assign wr_plus1 = (wr_ff    == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
   assign wr_plus2 = (wr_plus1 == PTR_W'(DEPTH - 1)) ? '0 : wr_plus1 + 1'b1;
   assign rd_plus1 = (rd_ff    == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;

   assign push_n     = {1'b0, emit.push_first} + {1'b0, emit.push_second};
   assign head_valid = (count_ff != '0);
   assign pop        = head_valid && head_taken;
   assign room_two   = (count_ff <= CNT_W'(DEPTH - 2));
   assign head       = slot_ff[rd_ff];

   // pointer and occupancy update
   always_comb begin
      wr_in    = emit.push_second ? wr_plus2 : (emit.push_first ? wr_plus1 : wr_ff);
      rd_in    = pop ? rd_plus1 : rd_ff;
      count_in = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (emit.push_first) begin
         slot_ff[wr_ff] <= emit.first;
      end
      if (emit.push_second) begin
         slot_ff[wr_plus1] <= emit.second;
      end
   end

   `PFT_ASSERT_IMPLIES(a_occupancy_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `PFT_ASSERT_IMPLIES(a_pair_fits, clock, reset, emit.push_second, emit.push_first && room_two)
   `PFT_ASSERT_NEXT(a_drain_step, clock, reset, pop && (push_n == 2'd0), count_ff == $past(count_ff) - 1'b1)

endmodule

// ===== hdl/polygon_fan_triangulator.sv =====
// ---------------------------------------------------------------------------
// Polygon fan triangulator
// Turns a stream of polygon vertex indices into triangle and quad words.
// ---------------------------------------------------------------------------
// Usage:
//   req_* takes one vertex index per word; a negative value closes the
//   polygon and carries the index as its bit complement.
//   rsp_* gives one primitive per word: four corners in tdata, the kind in
//   tuser (triangle, quad, or malformed for polygons under three vertices)
//   and tlast on the final word caused by a given index.
//   A four-vertex polygon comes out as one quad, any other as a fan of
//   triangles on its first vertex; output waits for the fourth or the closing vertex.
// Timing:
//   A result word is registered in the result queue when the index that
//   causes it is accepted. One index is accepted per cycle while req_tready is high. The fourth vertex of a
//   longer polygon yields two words, which the one-word-per-cycle result
//   port drains through the result queue while the receiver takes them.
//   req_tready is high while the queue has room for two words.
// Reset clears the polygon state and empties the queue. A stalled
// receiver holds the head word steady and backs up into req_tready once
// the queue lacks room for two words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module polygon_fan_triangulator #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // [31:0] raw_index
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,   // [30:0] corner_a, [61:31] corner_b,
                                      // [92:62] corner_c, [123:93] corner_d, zero pad
   output logic [1:0]    rsp_tuser,   // [1:0] prim_kind
   output logic          rsp_tlast    // last_of_run
);

   logic               accept;
   logic               room_two;
   pft_pkg::emit_type  emit;
   pft_pkg::prim_type  head;

   assign req_tready = room_two;
   assign accept     = req_tvalid && room_two;

   pft_fan u_fan (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .raw_index (req_tdata),
      .emit      (emit)
   );

   pft_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .room_two   (room_two),
      .head       (head),
      .head_valid (rsp_tvalid),
      .head_taken (rsp_tready)
   );

   // result word packing
   assign rsp_tdata = {4'b0000, head.corner_d, head.corner_c, head.corner_b, head.corner_a};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// Polygon fan triangulator testbench
// Feeds polygon index streams (directed corner cases, then random polygons of
// assorted sizes) through the request port under random stalls on both
// sides. A built-in fan/quad predictor queues the expected primitives, and
// the monitor checks each result word against the oldest one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned VTX_W          = pft_pkg::VTX_W;
   localparam int unsigned KIND_W         = pft_pkg::KIND_W;
   localparam int unsigned RANDOM_INDICES = 1500;
   localparam int unsigned QUIET_LIMIT    = 5000;
   localparam int unsigned HOLD_CYCLES    = 150;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [31:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [127:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          rsp_tlast;

   polygon_fan_triangulator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic [31:0]        index_feed[$];    // raw index words waiting to be sent
   pft_pkg::prim_type  expected_prims[$];
   int unsigned        n_taken = 0;      // index words accepted so far
   int unsigned        quiet_cycles = 0;
   int unsigned        errors = 0;
   int unsigned        hold_left = 0;
   bit                 hold_done = 1'b0;

   // polygon state of the predictor
   logic [VTX_W-1:0] apex_q, second_q, prev_q;
   int unsigned      count_q = 0;

   // no random idling on either side in this window
   wire calm = (n_taken >= 600) && (n_taken < 900);

   // ---- stimulus helpers ----
   function automatic logic [31:0] closing(input logic [VTX_W-1:0] v);
      return ~{1'b0, v};
   endfunction

   function automatic logic [VTX_W-1:0] pick_vertex();
      int unsigned mode;
      mode = $urandom_range(0, 9);
      if (mode < 5)
         return VTX_W'($urandom());
      else if (mode < 8)
         return VTX_W'($urandom_range(0, 15));
      else
         return {VTX_W{1'b1}} - VTX_W'($urandom_range(0, 3));
   endfunction

   function automatic void add_polygon(input int unsigned size);
      for (int unsigned i = 0; i < size; i++) begin
         if (i == size - 1)
            index_feed.push_back(closing(pick_vertex()));
         else
            index_feed.push_back({1'b0, pick_vertex()});
      end
   endfunction

   // ---- predictor: fan triangulation with the four-vertex quad case ----
   function automatic void push_prim(input logic [KIND_W-1:0] kind,
                                     input logic [VTX_W-1:0] a, b, c, d,
                                     input logic lst);
      pft_pkg::prim_type p;
      p.kind = kind;
      p.corner_a = a;
      p.corner_b = b;
      p.corner_c = c;
      p.corner_d = d;
      p.last = lst;
      expected_prims.push_back(p);
   endfunction

   function automatic void triangulate(input logic [31:0] raw);
      logic             closes;
      logic [VTX_W-1:0] v;
      closes = raw[31];
      v = closes ? ~raw[VTX_W-1:0] : raw[VTX_W-1:0];
      if (closes) begin
         case (count_q)
            0:       push_prim(pft_pkg::KIND_BAD, v, '0, '0, '0, 1'b1);
            1:       push_prim(pft_pkg::KIND_BAD, apex_q, v, '0, '0, 1'b1);
            2:       push_prim(pft_pkg::KIND_TRI, apex_q, second_q, v, '0, 1'b1);
            3:       push_prim(pft_pkg::KIND_QUAD, apex_q, second_q, prev_q, v, 1'b1);
            default: push_prim(pft_pkg::KIND_TRI, apex_q, prev_q, v, '0, 1'b1);
         endcase
         count_q = 0;
      end else begin
         case (count_q)
            0: apex_q = v;
            1: begin
               second_q = v;
               prev_q = v;
            end
            2: prev_q = v;
            3: begin
               // fourth vertex: not a quad, flush the first two triangles
               push_prim(pft_pkg::KIND_TRI, apex_q, second_q, prev_q, '0, 1'b0);
               push_prim(pft_pkg::KIND_TRI, apex_q, prev_q, v, '0, 1'b1);
               prev_q = v;
            end
            default: begin
               push_prim(pft_pkg::KIND_TRI, apex_q, prev_q, v, '0, 1'b1);
               prev_q = v;
            end
         endcase
         if (count_q < pft_pkg::CNT_QUAD)
            count_q = count_q + 1;
      end
   endfunction

   function automatic void check_field(input string name, input logic [VTX_W-1:0] exp_v,
                                       input logic [VTX_W-1:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
         errors++;
      end
   endfunction

   // ---- request driver ----
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (index_feed.size() > 0 && (calm || $urandom_range(0, 99) >= 16)) begin
            req_tdata  <= index_feed.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---- result receiver, with one long hold-off to back up the queue ----
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && n_taken >= 300) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= 16);
      end
   end

   // ---- monitor: predict on accepted indices, check accepted results ----
   always @(posedge clock) begin
      pft_pkg::prim_type exp_p;
      bit                moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_tvalid && req_tready) begin
            triangulate(req_tdata);
            n_taken <= n_taken + 1;
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            if (expected_prims.size() == 0) begin
               $error("unexpected result word: kind %0d", rsp_tuser);
               errors++;
            end else begin
               exp_p = expected_prims.pop_front();
               check_field("prim_kind", VTX_W'(exp_p.kind), VTX_W'(rsp_tuser));
               check_field("corner_a", exp_p.corner_a, rsp_tdata[30:0]);
               check_field("corner_b", exp_p.corner_b, rsp_tdata[61:31]);
               check_field("corner_c", exp_p.corner_c, rsp_tdata[92:62]);
               check_field("corner_d", exp_p.corner_d, rsp_tdata[123:93]);
               check_field("last_of_run", VTX_W'(exp_p.last), VTX_W'(rsp_tlast));
            end
         end
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // ---- stimulus and end of run ----
   initial begin
      int unsigned roll;
      // single-vertex polygons at both index extremes
      index_feed.push_back(closing('0));
      index_feed.push_back(32'h8000_0000);
      // two-vertex polygon
      index_feed.push_back({1'b0, {VTX_W{1'b1}}});
      index_feed.push_back(closing('0));
      // triangle, quad, five and six vertex fans
      index_feed.push_back(32'h0000_0000);
      index_feed.push_back(32'h7FFF_FFFF);
      index_feed.push_back(closing(31'h5555_5555));
      index_feed.push_back(32'h2AAA_AAAA);
      index_feed.push_back(32'h5555_5555);
      index_feed.push_back(32'h0000_0001);
      index_feed.push_back(closing({VTX_W{1'b1}}));
      for (int i = 1; i <= 4; i++)
         index_feed.push_back(32'(i));
      index_feed.push_back(closing(31'd5));
      for (int i = 10; i <= 14; i++)
         index_feed.push_back(32'(i));
      index_feed.push_back(closing(31'd15));

      // random polygons, mostly well formed, sizes biased near the quad case
      while (index_feed.size() < RANDOM_INDICES + 22) begin
         roll = $urandom_range(0, 99);
         if (roll < 6)       add_polygon(1);
         else if (roll < 12) add_polygon(2);
         else if (roll < 30) add_polygon(3);
         else if (roll < 55) add_polygon(4);
         else if (roll < 97) add_polygon($urandom_range(5, 10));
         else                add_polygon($urandom_range(11, 30));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (index_feed.size() != 0 || req_tvalid || expected_prims.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
